>>> hw/rtl/cartesian_to_spherical_assert.svh
// Assertion macros for the cartesian to spherical converter.
// Taken in by the RTL files that check their own logic; no other dependencies.
`ifndef CARTESIAN_TO_SPHERICAL_ASSERT_SVH
`define CARTESIAN_TO_SPHERICAL_ASSERT_SVH

`ifndef SYNTH
// Check a property on every rising edge, off while reset is asserted
`define C2S_CHECK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("c2s check failed");
// Check a condition whenever a qualifying valid is high
`define C2S_CHECK_VLD(lbl, clk, rst_n, vld, cond) \
	`C2S_CHECK(lbl, clk, rst_n, (vld) |-> (cond))
`else
`define C2S_CHECK(lbl, clk, rst_n, prop)
`define C2S_CHECK_VLD(lbl, clk, rst_n, vld, cond)
`endif

`endif

>>> hw/rtl/c2s_pkg.sv
// Shared constants, special-angle codes and the CORDIC arctangent table
// for the cartesian to spherical converter. No dependencies.
`default_nettype none

package c2s_pkg;

	// Parameter defaults
	localparam int DEF_COORD_WIDTH   = 24;
	localparam int DEF_CORDIC_STAGES = 24;

	// Coordinate normalization: largest magnitude brought to at least 2^30
	localparam int NORM_LO = 30;
	localparam int NSH_W   = 5;
	localparam int NX_W    = 33;
	localparam int SQ2_W   = 64;

	// CORDIC datapath: operands normalized to at least 2^57
	localparam int CORD_W    = 64;
	localparam int CORD_NORM = 57;
	localparam int CSH_W     = 6;
	localparam int ACC_W     = 34;
	localparam int ACC_HALF  = 1 << 30;
	localparam int ROUND_ADD = 128;
	localparam int ANG_SHIFT = 8;

	// Output angle scale: 2^23 is pi
	localparam int ANG_W    = 25;
	localparam int POLAR_W  = 24;
	localparam int ANG_PI   = 1 << 23;
	localparam int ANG_HALF = 1 << 22;

	// Special-case codes for an angle
	localparam int SPC_W = 3;
	localparam logic [SPC_W-1:0] SPC_NONE     = 3'd0;
	localparam logic [SPC_W-1:0] SPC_ZERO     = 3'd1;
	localparam logic [SPC_W-1:0] SPC_PI       = 3'd2;
	localparam logic [SPC_W-1:0] SPC_POS_HALF = 3'd3;
	localparam logic [SPC_W-1:0] SPC_NEG_HALF = 3'd4;

	// atan(2^-i), 2^31 standing for pi
	localparam int ATAN_TAB [0:31] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0
	};

	function automatic logic signed [ACC_W-1:0] atan_step(input int idx);
		return ACC_W'(ATAN_TAB[idx]);
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cartesian_to_spherical.sv
// Cartesian to spherical converter top level: length, polar angle, azimuth.
// Depends on c2s_pkg, c2s_isqrt, c2s_cordic and the assertion macro header.
//
//   channel  direction  handshake               payload
//   input    in         in_valid / in_ready     coord_x, coord_y, coord_z
//   output   out        out_valid / out_ready   vec_length, polar_angle,
//                                               azimuth_angle
//
// One transfer per cycle on each side. Latency is set mostly by the 33-stage
// 64-bit square root feeding the CORDIC chain.
// Reset clears only the valid bits of the pipeline.
// While a result waits on out_ready the whole pipeline holds and in_ready is
// low; empty slots inside the pipeline hold too and are not squeezed out.
`default_nettype none

`include "cartesian_to_spherical_assert.svh"

module cartesian_to_spherical #(
	parameter int COORD_WIDTH   = c2s_pkg::DEF_COORD_WIDTH,
	parameter int CORDIC_STAGES = c2s_pkg::DEF_CORDIC_STAGES
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [COORD_WIDTH-1:0]       coord_x,
	input  wire logic signed [COORD_WIDTH-1:0]       coord_y,
	input  wire logic signed [COORD_WIDTH-1:0]       coord_z,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic             [COORD_WIDTH-1:0]       vec_length,
	output logic             [c2s_pkg::POLAR_W-1:0]  polar_angle,
	output logic signed      [c2s_pkg::ANG_W-1:0]    azimuth_angle
);

	localparam int W       = COORD_WIDTH;
	localparam int PW      = $clog2(W);
	localparam int SQ_W    = 2 * W;
	localparam int NX_W    = c2s_pkg::NX_W;
	localparam int MAG_W   = NX_W - 1;
	localparam int SQ2_W   = c2s_pkg::SQ2_W;
	localparam int R_W     = SQ2_W / 2 + 1;
	localparam int R_LAT   = SQ2_W / 2 + 1;
	localparam int CL      = CORDIC_STAGES + 3;
	localparam int LEN_DLY = R_LAT + CL + 1 - W;
	localparam int DEPTH   = 5 + R_LAT + CL + 1;
	localparam int CW      = c2s_pkg::CORD_W;
	localparam int SHW     = c2s_pkg::NSH_W;
	localparam int PLW     = c2s_pkg::POLAR_W;
	localparam int AGW     = c2s_pkg::ANG_W;
	localparam logic [PLW-1:0]        POLAR_MAX = PLW'(c2s_pkg::ANG_PI);
	localparam logic signed [AGW-1:0] AZ_MAX    = AGW'(c2s_pkg::ANG_PI);

	// Global advance: hold everything while a result is not taken
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic [DEPTH-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[DEPTH-1];

	// Stage 1: capture the transfer
	logic signed [W-1:0] x_s1, y_s1, z_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= coord_x;
			y_s1 <= coord_y;
			z_s1 <= coord_z;
		end
	end

	// Stage 2: magnitudes, squares for the length, normalizing shift
	logic [W-1:0]   ax, ay, az, mx;
	logic [PW-1:0]  hi;
	logic [SHW-1:0] sh;

	always_comb begin
		ax = x_s1[W-1] ? W'(-x_s1) : W'(x_s1);
		ay = y_s1[W-1] ? W'(-y_s1) : W'(y_s1);
		az = z_s1[W-1] ? W'(-z_s1) : W'(z_s1);
		mx = (ax > ay) ? ax : ay;
		mx = (az > mx) ? az : mx;
		hi = '0;
		for (int i = 0; i < W; i++)
			if (mx[i]) hi = PW'(i);
		if (mx != '0 && 32'(hi) < 32'(c2s_pkg::NORM_LO))
			sh = SHW'(c2s_pkg::NORM_LO - 32'(hi));
		else
			sh = '0;
	end

	logic signed [W-1:0] x_s2, y_s2, z_s2;
	logic [SQ_W-1:0]     sqx_s2, sqy_s2, sqz_s2;
	logic [SHW-1:0]      sh_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			z_s2   <= z_s1;
			sqx_s2 <= SQ_W'(ax) * SQ_W'(ax);
			sqy_s2 <= SQ_W'(ay) * SQ_W'(ay);
			sqz_s2 <= SQ_W'(az) * SQ_W'(az);
			sh_s2  <= sh;
		end
	end

	// Stage 3: shifted coordinates and the three-term sum
	logic signed [NX_W-1:0] xs_s3, ys_s3, zs_s3;
	logic signed [W-1:0]    x_s3, y_s3;
	logic [SQ_W-1:0]        sum3_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			xs_s3   <= NX_W'(x_s2) <<< sh_s2;
			ys_s3   <= NX_W'(y_s2) <<< sh_s2;
			zs_s3   <= NX_W'(z_s2) <<< sh_s2;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			sum3_s3 <= sqx_s2 + sqy_s2 + sqz_s2;
		end
	end

	// Stage 4: squares of the shifted x and y
	logic [NX_W-1:0] mxs, mys;
	assign mxs = xs_s3[NX_W-1] ? NX_W'(-xs_s3) : NX_W'(xs_s3);
	assign mys = ys_s3[NX_W-1] ? NX_W'(-ys_s3) : NX_W'(ys_s3);

	logic [SQ2_W-1:0]       sqa_s4, sqb_s4;
	logic signed [NX_W-1:0] zs_s4;
	logic signed [W-1:0]    x_s4, y_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s4 <= SQ2_W'(mxs[MAG_W-1:0]) * SQ2_W'(mxs[MAG_W-1:0]);
			sqb_s4 <= SQ2_W'(mys[MAG_W-1:0]) * SQ2_W'(mys[MAG_W-1:0]);
			zs_s4  <= zs_s3;
			x_s4   <= x_s3;
			y_s4   <= y_s3;
		end
	end

	// Stage 5: planar sum of squares
	logic [SQ2_W-1:0]       sum2_s5;
	logic signed [NX_W-1:0] zs_s5;
	logic signed [W-1:0]    x_s5, y_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			sum2_s5 <= sqa_s4 + sqb_s4;
			zs_s5   <= zs_s4;
			x_s5    <= x_s4;
			y_s5    <= y_s4;
		end
	end

	// Length root and planar radius
	logic [W:0]     len_rt;
	logic [R_W-1:0] r12;

	c2s_isqrt #(.IN_W(SQ_W)) u_len_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sum3_s3),
		.root (len_rt)
	);

	c2s_isqrt #(.IN_W(SQ2_W)) u_rad_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sum2_s5),
		.root (r12)
	);

	// Delay z and the raw x, y alongside the radius root
	logic signed [NX_W-1:0] zs_dl [0:R_LAT-1];
	logic signed [W-1:0]    x_dl  [0:R_LAT-1];
	logic signed [W-1:0]    y_dl  [0:R_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			zs_dl[0] <= zs_s5;
			x_dl[0]  <= x_s5;
			y_dl[0]  <= y_s5;
			for (int i = 1; i < R_LAT; i++) begin
				zs_dl[i] <= zs_dl[i-1];
				x_dl[i]  <= x_dl[i-1];
				y_dl[i]  <= y_dl[i-1];
			end
		end
	end

	// Delay the length to meet the angles
	logic [W:0] len_dl [0:LEN_DLY-1];
	always_ff @(posedge clk) begin
		if (en) begin
			len_dl[0] <= len_rt;
			for (int i = 1; i < LEN_DLY; i++)
				len_dl[i] <= len_dl[i-1];
		end
	end

	// Two angle units in lockstep
	logic signed [CW-1:0]  pol_x, pol_y, az_x, az_y;
	logic signed [AGW-1:0] pol_ang, az_ang;

	assign pol_x = CW'(zs_dl[R_LAT-1]);
	assign pol_y = signed'(CW'(r12));
	assign az_x  = CW'(x_dl[R_LAT-1]);
	assign az_y  = CW'(y_dl[R_LAT-1]);

	c2s_cordic #(.STAGES(CORDIC_STAGES)) u_polar (
		.clk   (clk),
		.en    (en),
		.vec_x (pol_x),
		.vec_y (pol_y),
		.angle (pol_ang)
	);

	c2s_cordic #(.STAGES(CORDIC_STAGES)) u_azim (
		.clk   (clk),
		.en    (en),
		.vec_x (az_x),
		.vec_y (az_y),
		.angle (az_ang)
	);

	// Output register; drop negative polar angles to zero
	always_ff @(posedge clk) begin
		if (en) begin
			vec_length    <= len_dl[LEN_DLY-1][W-1:0];
			polar_angle   <= pol_ang[AGW-1] ? '0 : pol_ang[PLW-1:0];
			azimuth_angle <= az_ang;
		end
	end

	`C2S_CHECK_VLD(a_polar_range, clk, arst_n, out_valid, polar_angle <= POLAR_MAX)
	`C2S_CHECK_VLD(a_azim_range, clk, arst_n, out_valid, (azimuth_angle <= AZ_MAX) && (azimuth_angle >= -AZ_MAX))
	`C2S_CHECK_VLD(a_zero_vec, clk, arst_n, out_valid && (vec_length == '0), (polar_angle == '0) && (azimuth_angle == '0))
	`C2S_CHECK(a_stall_blocks, clk, arst_n, (out_valid && !out_ready) |-> !in_ready)

endmodule

`default_nettype wire

>>> hw/rtl/c2s_isqrt.sv
// Pipelined integer square root, rounded to nearest with ties upward.
// One result bit per stage plus a rounding stage; uses no package items.
`default_nettype none

module c2s_isqrt #(
	parameter int IN_W = 48
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [IN_W-1:0]   rad,
	output logic      [IN_W/2:0]   root
);

	localparam int K    = IN_W / 2;
	localparam int RT_W = K + 1;

	logic [IN_W-1:0] op_s  [0:K];
	logic [IN_W-1:0] res_s [0:K];

	assign op_s[0]  = rad;
	assign res_s[0] = '0;

	// One restoring step per stage, trial bit walking down by powers of four
	for (genvar k = 0; k < K; k++) begin : g_step
		localparam logic [IN_W-1:0] BIT = IN_W'(1) << (2 * (K - 1 - k));
		logic [IN_W-1:0] trial;

		assign trial = res_s[k] + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (op_s[k] >= trial) begin
					op_s[k+1]  <= op_s[k] - trial;
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					op_s[k+1]  <= op_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
			end
		end
	end

	// Round up when the remainder exceeds the root
	always_ff @(posedge clk) begin
		if (en) begin
			if (op_s[K] > res_s[K])
				root <= res_s[K][RT_W-1:0] + RT_W'(1);
			else
				root <= res_s[K][RT_W-1:0];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/c2s_cordic.sv
// Pipelined vectoring CORDIC giving atan2(vec_y, vec_x) on the 2^23-per-pi
// scale. Uses c2s_pkg for widths, special codes and the arctangent table.
`default_nettype none

module c2s_cordic #(
	parameter int STAGES = c2s_pkg::DEF_CORDIC_STAGES
) (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire logic signed [c2s_pkg::CORD_W-1:0]  vec_x,
	input  wire logic signed [c2s_pkg::CORD_W-1:0]  vec_y,
	output logic signed      [c2s_pkg::ANG_W-1:0]   angle
);

	localparam int CW    = c2s_pkg::CORD_W;
	localparam int AW    = c2s_pkg::ACC_W;
	localparam int SW    = c2s_pkg::CSH_W;
	localparam int CDW   = c2s_pkg::SPC_W;
	localparam int OW    = c2s_pkg::ANG_W;
	localparam logic signed [AW-1:0] PI_A   = AW'(c2s_pkg::ANG_PI);
	localparam logic signed [AW-1:0] HALF_A = AW'(c2s_pkg::ANG_HALF);
	localparam logic signed [AW-1:0] QTR_AC = AW'(c2s_pkg::ACC_HALF);

	// Stage 1: special cases and normalizing shift amount
	logic [CW-1:0]  ax, ay, mx;
	logic [SW-1:0]  hi, sh;
	logic [CDW-1:0] code;

	always_comb begin
		ax = vec_x[CW-1] ? CW'(-vec_x) : CW'(vec_x);
		ay = vec_y[CW-1] ? CW'(-vec_y) : CW'(vec_y);
		mx = (ax > ay) ? ax : ay;
		hi = '0;
		for (int i = 0; i < CW; i++)
			if (mx[i]) hi = SW'(i);
		if (32'(hi) < 32'(c2s_pkg::CORD_NORM))
			sh = SW'(c2s_pkg::CORD_NORM - 32'(hi));
		else
			sh = '0;
		if (vec_y == '0)
			code = vec_x[CW-1] ? c2s_pkg::SPC_PI : c2s_pkg::SPC_ZERO;
		else if (vec_x == '0)
			code = vec_y[CW-1] ? c2s_pkg::SPC_NEG_HALF : c2s_pkg::SPC_POS_HALF;
		else
			code = c2s_pkg::SPC_NONE;
	end

	logic signed [CW-1:0] vx_s1, vy_s1;
	logic [SW-1:0]        sh_s1;
	logic [CDW-1:0]       code_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1   <= vec_x;
			vy_s1   <= vec_y;
			sh_s1   <= sh;
			code_s1 <= code;
		end
	end

	// Stage 2: normalize, then turn left half-plane vectors by a quarter turn
	logic signed [CW-1:0] nx, ny;
	assign nx = vx_s1 <<< sh_s1;
	assign ny = vy_s1 <<< sh_s1;

	logic signed [CW-1:0] vx_c  [0:STAGES];
	logic signed [CW-1:0] vy_c  [0:STAGES];
	logic signed [AW-1:0] acc_c [0:STAGES];
	logic [CDW-1:0]       code_c [0:STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			code_c[0] <= code_s1;
			if (nx[CW-1]) begin
				if (!ny[CW-1]) begin
					vx_c[0]  <= ny;
					vy_c[0]  <= -nx;
					acc_c[0] <= QTR_AC;
				end else begin
					vx_c[0]  <= -ny;
					vy_c[0]  <= nx;
					acc_c[0] <= -QTR_AC;
				end
			end else begin
				vx_c[0]  <= nx;
				vy_c[0]  <= ny;
				acc_c[0] <= '0;
			end
		end
	end

	// Micro-rotations, one per stage, driving y toward zero
	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		localparam logic signed [AW-1:0] STEP = c2s_pkg::atan_step(i);
		logic signed [CW-1:0] dx, dy;

		assign dx = vy_c[i] >>> i;
		assign dy = vx_c[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				code_c[i+1] <= code_c[i];
				if (!vy_c[i][CW-1]) begin
					vx_c[i+1]  <= vx_c[i] + dx;
					vy_c[i+1]  <= vy_c[i] - dy;
					acc_c[i+1] <= acc_c[i] + STEP;
				end else begin
					vx_c[i+1]  <= vx_c[i] - dx;
					vy_c[i+1]  <= vy_c[i] + dy;
					acc_c[i+1] <= acc_c[i] - STEP;
				end
			end
		end
	end

	// Final: round to output scale, clamp, apply special cases
	logic signed [AW-1:0] rsum, rsh, rcl, rout;

	always_comb begin
		rsum = acc_c[STAGES] + AW'(c2s_pkg::ROUND_ADD);
		rsh  = rsum >>> c2s_pkg::ANG_SHIFT;
		rcl  = rsh;
		if (rsh > PI_A)
			rcl = PI_A;
		if (rsh < -PI_A)
			rcl = -PI_A;
		case (code_c[STAGES])
			c2s_pkg::SPC_NONE:     rout = rcl;
			c2s_pkg::SPC_ZERO:     rout = '0;
			c2s_pkg::SPC_PI:       rout = PI_A;
			c2s_pkg::SPC_POS_HALF: rout = HALF_A;
			c2s_pkg::SPC_NEG_HALF: rout = -HALF_A;
			default:               rout = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			angle <= OW'(rout);
	end

endmodule

`default_nettype wire
